// File: rtl/core/avt_pkg.sv
// ----------------------------------------------------------------------------
// avt_pkg: shared types and constants for the affine vertex transform
// Register indexes, register and port widths, the coefficient bundle that
// feeds one output column and the result that comes back from it.
// ----------------------------------------------------------------------------
`default_nettype none

package avt_pkg;

  localparam int REG_W    = 64;   // configuration register width
  localparam int HALF_W   = 32;   // one coefficient inside a register
  localparam int IO_W     = 32;   // coordinate port width
  localparam int NUM_REGS = 6;
  localparam int IDX_W    = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_COL_X01 = 3'd0;
  localparam logic [IDX_W-1:0] REG_COL_X23 = 3'd1;
  localparam logic [IDX_W-1:0] REG_COL_Y01 = 3'd2;
  localparam logic [IDX_W-1:0] REG_COL_Y23 = 3'd3;
  localparam logic [IDX_W-1:0] REG_COL_Z01 = 3'd4;
  localparam logic [IDX_W-1:0] REG_COL_Z23 = 3'd5;

  // Coefficients of one column: m0..m2 scale x, y, z; m3 is the translation.
  typedef struct packed {
    logic [HALF_W-1:0] m0;
    logic [HALF_W-1:0] m1;
    logic [HALF_W-1:0] m2;
    logic [HALF_W-1:0] m3;
  } avt_coef_t;

  // One transformed coordinate, already sign-extended to the port width.
  typedef struct packed {
    logic [IO_W-1:0] value;
    logic            sat;
  } avt_col_res_t;

endpackage

`default_nettype wire

// File: rtl/core/avt_column.sv
// ----------------------------------------------------------------------------
// avt_column: pipelined dot product for one output coordinate
// Multiply, two-level exact sum, then round half up and saturate.
// Four register stages from operands to result.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_column import avt_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic signed [COORD_WIDTH-1:0] x,
  input  wire logic signed [COORD_WIDTH-1:0] y,
  input  wire logic signed [COORD_WIDTH-1:0] z,
  input  wire avt_coef_t                     coef,
  output avt_col_res_t                       res
);

  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int TR_W   = COORD_WIDTH + FRAC_BITS;
  localparam int ACC_W  = ((PROD_W > TR_W) ? PROD_W : TR_W) + 2;
  localparam int RND_W  = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] MAXV =
    RND_W'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
  localparam logic signed [RND_W-1:0] MINV = -MAXV - RND_W'(1);

  logic signed [COORD_WIDTH-1:0] m0, m1, m2, m3;
  logic signed [PROD_W-1:0]      p0, p1, p2;
  logic signed [COORD_WIDTH-1:0] tr;
  logic signed [ACC_W-1:0]       sum_a, sum_b, sum;
  logic signed [RND_W-1:0]       rnd;
  logic signed [COORD_WIDTH-1:0] clipped;
  logic                          clip;

  assign m0 = signed'(coef.m0[COORD_WIDTH-1:0]);
  assign m1 = signed'(coef.m1[COORD_WIDTH-1:0]);
  assign m2 = signed'(coef.m2[COORD_WIDTH-1:0]);
  assign m3 = signed'(coef.m3[COORD_WIDTH-1:0]);

  // Products
  always_ff @(posedge clk) begin
    p0 <= x * m0;
    p1 <= y * m1;
    p2 <= z * m2;
    tr <= m3;
  end

  // Partial sums; translation aligned to the product scale, rounding bit added
  always_ff @(posedge clk) begin
    sum_a <= ACC_W'(p0) + ACC_W'(p1);
    sum_b <= ACC_W'(p2) + (ACC_W'(tr) <<< FRAC_BITS) + HALF_LSB;
  end

  always_ff @(posedge clk) begin
    sum <= sum_a + sum_b;
  end

  always_comb begin
    rnd = RND_W'(sum >>> FRAC_BITS);
    clip = 1'b0;
    clipped = rnd[COORD_WIDTH-1:0];
    if (rnd > MAXV) begin
      clipped = MAXV[COORD_WIDTH-1:0];
      clip = 1'b1;
    end else if (rnd < MINV) begin
      clipped = MINV[COORD_WIDTH-1:0];
      clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res.value <= IO_W'(clipped);
    res.sat   <= clip;
  end

endmodule

`default_nettype wire

// File: rtl/core/affine_vertex_transform_top.sv
// ----------------------------------------------------------------------------
// affine_vertex_transform_top: 4x3 affine vertex transform, signed fixed point
// Path from the accepting edge to done: input register, four column stages.
// Throughput: one vertex per cycle outside reset; the three column multiplier
// pipelines take a new operand set every cycle and the receiver cannot stall
// them. Reset (synchronous): loads the identity matrix and drops all
// transactions in flight; busy is high only while rst is high.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_vertex_transform_top import avt_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Vertex command
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [IO_W-1:0]  in_x,
  input  wire logic signed [IO_W-1:0]  in_y,
  input  wire logic signed [IO_W-1:0]  in_z,
  // Result strobe
  output logic                         done,
  output logic signed [IO_W-1:0]       out_x,
  output logic signed [IO_W-1:0]       out_y,
  output logic signed [IO_W-1:0]       out_z,
  output logic                         overflow,
  // Configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [REG_W-1:0]        cfg_data
);

  // Input register plus four column stages
  localparam int LAT = 5;

  localparam logic [REG_W-1:0] ONE_FX = REG_W'(1) << FRAC_BITS;

  // Saturation limits as seen on the 32-bit ports, for checking only
  localparam logic signed [IO_W-1:0] OUT_MAX =
    IO_W'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
  localparam logic signed [IO_W-1:0] OUT_MIN = -OUT_MAX - IO_W'(1);

  logic [REG_W-1:0]              cfg [NUM_REGS];
  logic [LAT-1:0]                vld;
  logic                          accept;
  logic signed [COORD_WIDTH-1:0] vx, vy, vz;
  avt_coef_t                     coef_x, coef_y, coef_z;
  avt_col_res_t                  res_x, res_y, res_z;

  // The pipeline never stalls, so the only time a command is refused is reset.
  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers: reset to the identity, ignore writes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_COL_X01] <= ONE_FX;
      cfg[REG_COL_X23] <= '0;
      cfg[REG_COL_Y01] <= ONE_FX << HALF_W;
      cfg[REG_COL_Y23] <= '0;
      cfg[REG_COL_Z01] <= '0;
      cfg[REG_COL_Z23] <= ONE_FX;
    end else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // Split each column's register pair into its four coefficients
  assign coef_x = '{m0: cfg[REG_COL_X01][HALF_W-1:0], m1: cfg[REG_COL_X01][REG_W-1:HALF_W],
                    m2: cfg[REG_COL_X23][HALF_W-1:0], m3: cfg[REG_COL_X23][REG_W-1:HALF_W]};
  assign coef_y = '{m0: cfg[REG_COL_Y01][HALF_W-1:0], m1: cfg[REG_COL_Y01][REG_W-1:HALF_W],
                    m2: cfg[REG_COL_Y23][HALF_W-1:0], m3: cfg[REG_COL_Y23][REG_W-1:HALF_W]};
  assign coef_z = '{m0: cfg[REG_COL_Z01][HALF_W-1:0], m1: cfg[REG_COL_Z01][REG_W-1:HALF_W],
                    m2: cfg[REG_COL_Z23][HALF_W-1:0], m3: cfg[REG_COL_Z23][REG_W-1:HALF_W]};

  // Capture the vertex every cycle; only the low COORD_WIDTH bits count
  always_ff @(posedge clk) begin
    vx <= signed'(in_x[COORD_WIDTH-1:0]);
    vy <= signed'(in_y[COORD_WIDTH-1:0]);
    vz <= signed'(in_z[COORD_WIDTH-1:0]);
  end

  // Valid bits advance in step with the column stages; reset drops them all
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  avt_column #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_col_x (
    .clk  (clk),
    .x    (vx),
    .y    (vy),
    .z    (vz),
    .coef (coef_x),
    .res  (res_x)
  );

  avt_column #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_col_y (
    .clk  (clk),
    .x    (vx),
    .y    (vy),
    .z    (vz),
    .coef (coef_y),
    .res  (res_y)
  );

  avt_column #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_col_z (
    .clk  (clk),
    .x    (vx),
    .y    (vy),
    .z    (vz),
    .coef (coef_z),
    .res  (res_z)
  );

  // Results come straight from the column output registers
  assign done     = vld[LAT-1];
  assign out_x    = signed'(res_x.value);
  assign out_y    = signed'(res_y.value);
  assign out_z    = signed'(res_z.value);
  assign overflow = res_x.sat | res_y.sat | res_z.sat;

  // Every result strobe matches an earlier accepted transaction
  a_done_matches_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted transaction");

  // An accepted transaction produces a strobe unless a reset comes in between
  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT (done || $past(rst, 1) || $past(rst, 2) || $past(rst, 3)
                                || $past(rst, 4) || rst))
    else $error("accepted transaction lost in the pipeline");

  // A flagged overflow leaves at least one coordinate pinned at a limit
  a_overflow_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |->
      (out_x == OUT_MAX || out_x == OUT_MIN || out_y == OUT_MAX ||
       out_y == OUT_MIN || out_z == OUT_MAX || out_z == OUT_MIN))
    else $error("overflow flagged but no coordinate saturated");

endmodule

`default_nettype wire
